// ----- rtl/core/tsgr_pkg.sv -----
// Shared types and constants for the track spike and gap rejector.
// Used by tsgr_ctrl, tsgr_dp and the top level; depends on nothing.
package tsgr_pkg;

   localparam int TIME_W     = 48;
   localparam int POS_W      = 31;
   localparam int SPEED_W    = 17;
   localparam int GAP_W      = 27;
   localparam int CAUSE_W    = 3;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 8;

   // configuration register indexes
   localparam logic CSR_SPEED_LIM = 1'b0;
   localparam logic CSR_GAP_LIMIT = 1'b1;

   localparam logic [SPEED_W-1:0] SPEED_LIM_RST = 17'd3000;
   localparam logic [GAP_W-1:0]   GAP_LIMIT_RST = 27'd10000;

   // result cause codes
   localparam logic [CAUSE_W-1:0] CAUSE_KEPT       = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_FIRST      = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_NORMAL_REJ = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_RECOV_REJ  = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_FIRST_GOOD = 3'd4;

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_CHECK, ST_DECIDE} ctl_state_type;
   typedef enum logic [1:0] {MODE_NORMAL, MODE_RECOVERY, MODE_FIRST_GOOD} mode_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_SQ_X,
      MUL_SQ_Y,
      MUL_SQ_Z,
      MUL_DT_LO,
      MUL_DT_HI,
      MUL_D2_LO,
      MUL_D2_HI,
      MUL_T_LL,
      MUL_T_LH,
      MUL_T_HH
   } mul_op_type;

   typedef struct packed {
      logic       capture;
      logic       eval;
      logic       load_ref;
      logic       ref_prev;
      mul_op_type mul_op;
      logic       check_done;
      logic       anchor_wr;
      logic       prev_wr;
   } dp_cmd_type;

   typedef struct packed {
      logic start;
      logic terr;
      logic gap_a;
      logic gap_c;
      logic fast_a;
      logic fast_c;
   } dp_status_type;

   typedef struct packed {
      logic             wr;
      logic             index;
      logic [GAP_W-1:0] data;
   } csr_wr_type;

endpackage

// ----- rtl/core/track_spike_gap_rejector.sv -----
// Top level of the track spike and gap rejector: stream ports, field packing,
// controller and datapath. Depends on tsgr_pkg, tsgr_ctrl and tsgr_dp.
//
// One fix in, one verdict out. A fix that starts a track goes from acceptance to
// the result register through the evaluate and decide states only; in normal
// mode one speed test lies between them, otherwise two, each on the single
// shared 32x32 multiplier (distance squares, time span times speed limit,
// scaling by 10^6, squaring): one against the anchor and, outside normal mode,
// one more against the previous fix. A new fix is taken as soon as the previous
// verdict is in the output register, even while that verdict still waits to be
// taken. Configuration writes are always taken and should be made while idle.
module track_spike_gap_rejector
   import tsgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // time_ms[47:0], pos_x[78:48], pos_y[109:79], pos_z[140:110], zero[143:141]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // track_start[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // drop[0], cause[3:1], time_error[4], zero[7:5]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [GAP_W-1:0]      csr_wdata
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   csr_wr_type         csr;
   logic               rsp_drop;
   logic [CAUSE_W-1:0] rsp_cause;
   logic               rsp_terr;

   assign csr_ready = 1'b1;
   assign csr.wr    = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   assign rsp_tdata = {3'b000, rsp_terr, rsp_cause, rsp_drop};

   tsgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_drop   (rsp_drop),
      .rsp_cause  (rsp_cause),
      .rsp_terr   (rsp_terr),
      .cmd        (cmd),
      .status     (status)
   );

   tsgr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr       (csr),
      .req_start (req_tuser),
      .req_time  (req_tdata[47:0]),
      .req_pos_x (req_tdata[78:48]),
      .req_pos_y (req_tdata[109:79]),
      .req_pos_z (req_tdata[140:110])
   );

endmodule

// ----- rtl/core/tsgr_dp.sv -----
// Datapath: fix registers, anchor and previous fix, configuration registers,
// and a shared 32x32 multiply-accumulate unit for the speed tests. Uses tsgr_pkg.
module tsgr_dp
   import tsgr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  csr_wr_type             csr,
   input  logic                   req_start,
   input  logic [TIME_W-1:0]      req_time,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z
);

   typedef enum logic [1:0] {SH_0, SH_32, SH_33, SH_64} shift_type;
   typedef enum logic [1:0] {SAVE_NONE, SAVE_D2, SAVE_TV, SAVE_LHS} save_type;

   localparam logic [31:0] SCALE_1E6 = 32'd1000000;

   logic [SPEED_W-1:0] speed_lim_ff;
   logic [GAP_W-1:0]   gap_limit_ff;

   logic                    in_start_ff;
   logic [TIME_W-1:0]       in_time_ff;
   logic signed [POS_W-1:0] in_pos_ff     [3];
   logic [TIME_W-1:0]       anchor_time_ff;
   logic signed [POS_W-1:0] anchor_pos_ff [3];
   logic [TIME_W-1:0]       prev_time_ff;
   logic signed [POS_W-1:0] prev_pos_ff   [3];

   logic [POS_W-1:0]  diff_ff [3];
   logic [TIME_W-1:0] dt_ff;

   logic [63:0]  prod_ff;
   logic         tag_vld_ff;
   logic         tag_clr_ff;
   shift_type    tag_sh_ff;
   save_type     tag_save_ff;
   logic [127:0] acc_ff;
   logic [63:0]  d2_ff;
   logic [63:0]  tv_ff;
   logic [83:0]  lhs_ff;

   logic terr_ff, gap_a_ff, gap_c_ff, fast_a_ff, fast_c_ff;

   logic [31:0]  mul_a, mul_b;
   logic         op_vld, op_clr;
   shift_type    op_sh;
   save_type     op_save;
   logic [127:0] shifted, acc_base, acc_in;
   logic [TIME_W-1:0] dt_a, dt_c, ref_time;
   logic         fast_in;

   function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                 logic signed [POS_W-1:0] b);
      logic signed [POS_W:0] d;
      logic        [POS_W:0] n;
      begin
         d = (POS_W+1)'(a) - (POS_W+1)'(b);
         n = -d;
         abs_diff = d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
      end
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_lim_ff <= SPEED_LIM_RST;
         gap_limit_ff <= GAP_LIMIT_RST;
      end else if (csr.wr) begin
         unique case (csr.index)
            CSR_SPEED_LIM: speed_lim_ff <= csr.data[SPEED_W-1:0];
            CSR_GAP_LIMIT: gap_limit_ff <= csr.data;
         endcase
      end
   end

   // fix, anchor and previous fix
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_start_ff  <= req_start;
         in_time_ff   <= req_time;
         in_pos_ff[0] <= req_pos_x;
         in_pos_ff[1] <= req_pos_y;
         in_pos_ff[2] <= req_pos_z;
      end
      if (cmd.anchor_wr) begin
         anchor_time_ff <= in_time_ff;
         anchor_pos_ff  <= in_pos_ff;
      end
      if (cmd.prev_wr) begin
         prev_time_ff <= in_time_ff;
         prev_pos_ff  <= in_pos_ff;
      end
   end

   // time tests
   assign dt_a = in_time_ff - anchor_time_ff;
   assign dt_c = in_time_ff - prev_time_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         terr_ff  <= in_time_ff <= prev_time_ff;
         gap_a_ff <= dt_a >= TIME_W'(gap_limit_ff);
         gap_c_ff <= dt_c > TIME_W'(gap_limit_ff);
      end
   end

   // per-axis distance and time span against the chosen reference
   assign ref_time = cmd.ref_prev ? prev_time_ff : anchor_time_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_ref) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= abs_diff(in_pos_ff[i],
                                   cmd.ref_prev ? prev_pos_ff[i] : anchor_pos_ff[i]);
         end
         dt_ff <= in_time_ff - ref_time;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      op_vld  = 1'b1;
      op_clr  = 1'b0;
      op_sh   = SH_0;
      op_save = SAVE_NONE;
      unique case (cmd.mul_op)
         MUL_NONE: op_vld = 1'b0;
         MUL_SQ_X: begin
            mul_a  = 32'(diff_ff[0]);
            mul_b  = 32'(diff_ff[0]);
            op_clr = 1'b1;
         end
         MUL_SQ_Y: begin
            mul_a = 32'(diff_ff[1]);
            mul_b = 32'(diff_ff[1]);
         end
         MUL_SQ_Z: begin
            mul_a   = 32'(diff_ff[2]);
            mul_b   = 32'(diff_ff[2]);
            op_save = SAVE_D2;
         end
         MUL_DT_LO: begin
            mul_a  = dt_ff[31:0];
            mul_b  = 32'(speed_lim_ff);
            op_clr = 1'b1;
         end
         MUL_DT_HI: begin
            mul_a   = 32'(dt_ff[TIME_W-1:32]);
            mul_b   = 32'(speed_lim_ff);
            op_sh   = SH_32;
            op_save = SAVE_TV;
         end
         MUL_D2_LO: begin
            mul_a  = d2_ff[31:0];
            mul_b  = SCALE_1E6;
            op_clr = 1'b1;
         end
         MUL_D2_HI: begin
            mul_a   = d2_ff[63:32];
            mul_b   = SCALE_1E6;
            op_sh   = SH_32;
            op_save = SAVE_LHS;
         end
         MUL_T_LL: begin
            mul_a  = tv_ff[31:0];
            mul_b  = tv_ff[31:0];
            op_clr = 1'b1;
         end
         MUL_T_LH: begin
            mul_a = tv_ff[31:0];
            mul_b = tv_ff[63:32];
            op_sh = SH_33;
         end
         MUL_T_HH: begin
            mul_a = tv_ff[63:32];
            mul_b = tv_ff[63:32];
            op_sh = SH_64;
         end
         default: op_vld = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= mul_a * mul_b;
      tag_clr_ff  <= op_clr;
      tag_sh_ff   <= op_sh;
      tag_save_ff <= op_save;
      if (reset) begin
         tag_vld_ff <= 1'b0;
      end else begin
         tag_vld_ff <= op_vld;
      end
   end

   // accumulate stage
   always_comb begin
      case (tag_sh_ff)
         SH_0:    shifted = {64'd0, prod_ff};
         SH_32:   shifted = {32'd0, prod_ff, 32'd0};
         SH_33:   shifted = {31'd0, prod_ff, 33'd0};
         default: shifted = {prod_ff, 64'd0};
      endcase
      acc_base = tag_clr_ff ? '0 : acc_ff;
      acc_in   = acc_base + shifted;
   end

   always_ff @(posedge clock) begin
      if (tag_vld_ff) begin
         acc_ff <= acc_in;
         case (tag_save_ff)
            SAVE_D2:  d2_ff  <= acc_in[63:0];
            SAVE_TV:  tv_ff  <= acc_in[63:0];
            SAVE_LHS: lhs_ff <= acc_in[83:0];
            default:  ;
         endcase
      end
   end

   // too fast: d2 * 1e6 > (dt * speed limit)^2; with a nonzero limit never for
   // spans of 2^46 ms and up, with a zero limit any movement is too fast
   assign fast_in = (128'(lhs_ff) > acc_ff) &&
                    ((dt_ff[TIME_W-1:TIME_W-2] == 2'b00) || (speed_lim_ff == '0));

   always_ff @(posedge clock) begin
      if (cmd.check_done) begin
         if (cmd.ref_prev) begin
            fast_c_ff <= fast_in;
         end else begin
            fast_a_ff <= fast_in;
         end
      end
   end

   assign status.start  = in_start_ff;
   assign status.terr   = terr_ff;
   assign status.gap_a  = gap_a_ff;
   assign status.gap_c  = gap_c_ff;
   assign status.fast_a = fast_a_ff;
   assign status.fast_c = fast_c_ff;

endmodule

// ----- rtl/core/tsgr_ctrl.sv -----
// Controller: sequences the speed tests, keeps mode and anchor validity,
// decides each fix and holds the result register. Uses tsgr_pkg.
module tsgr_ctrl
   import tsgr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               rsp_drop,
   output logic [CAUSE_W-1:0] rsp_cause,
   output logic               rsp_terr,
   output dp_cmd_type         cmd,
   input  dp_status_type      status
);

   localparam logic [3:0] STEP_LOAD = 4'd0;
   localparam logic [3:0] STEP_CMP  = 4'd12;

   ctl_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [3:0]    step_ff, step_in;
   logic          chk_prev_ff, chk_prev_in;
   logic          anchor_valid_ff, anchor_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          drop_ff, drop_in;
   logic [CAUSE_W-1:0] cause_ff, cause_in;
   logic          terr_ff, terr_in;
   logic          first, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         mode_ff         <= MODE_NORMAL;
         step_ff         <= STEP_LOAD;
         chk_prev_ff     <= 1'b0;
         anchor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         step_ff         <= step_in;
         chk_prev_ff     <= chk_prev_in;
         anchor_valid_ff <= anchor_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff  <= drop_in;
      cause_ff <= cause_in;
      terr_ff  <= terr_in;
   end

   assign first    = status.start || !anchor_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      step_in         = step_ff;
      chk_prev_in     = chk_prev_ff;
      anchor_valid_in = anchor_valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      drop_in         = drop_ff;
      cause_in        = cause_ff;
      terr_in         = terr_ff;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.mul_op      = MUL_NONE;
      cmd.ref_prev    = chk_prev_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end

         ST_EVAL: begin
            cmd.eval    = 1'b1;
            chk_prev_in = 1'b0;
            step_in     = STEP_LOAD;
            state_in    = first ? ST_DECIDE : ST_CHECK;
         end

         ST_CHECK: begin
            // one speed test: distances, span, scaled sides, then compare
            case (step_ff)
               4'd0:    cmd.load_ref = 1'b1;
               4'd1:    cmd.mul_op = MUL_SQ_X;
               4'd2:    cmd.mul_op = MUL_SQ_Y;
               4'd3:    cmd.mul_op = MUL_SQ_Z;
               4'd4:    cmd.mul_op = MUL_DT_LO;
               4'd5:    cmd.mul_op = MUL_DT_HI;
               4'd6:    cmd.mul_op = MUL_D2_LO;
               4'd7:    cmd.mul_op = MUL_D2_HI;
               4'd8:    cmd.mul_op = MUL_T_LL;
               4'd9:    cmd.mul_op = MUL_T_LH;
               4'd10:   cmd.mul_op = MUL_T_HH;
               default: cmd.mul_op = MUL_NONE;
            endcase
            if (step_ff == STEP_CMP) begin
               cmd.check_done = 1'b1;
               step_in        = STEP_LOAD;
               if (!chk_prev_ff && mode_ff != MODE_NORMAL) begin
                  chk_prev_in = 1'b1;
               end else begin
                  state_in = ST_DECIDE;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               drop_in      = 1'b0;
               terr_in      = 1'b0;
               cause_in     = CAUSE_KEPT;
               if (first) begin
                  cause_in        = CAUSE_FIRST;
                  anchor_valid_in = 1'b1;
                  mode_in         = MODE_NORMAL;
                  cmd.anchor_wr   = 1'b1;
                  cmd.prev_wr     = 1'b1;
               end else if (status.terr) begin
                  // hold all state
                  drop_in  = 1'b1;
                  terr_in  = 1'b1;
                  cause_in = (mode_ff == MODE_NORMAL) ? CAUSE_NORMAL_REJ : CAUSE_RECOV_REJ;
               end else begin
                  cmd.prev_wr = 1'b1;
                  if (mode_ff == MODE_NORMAL) begin
                     if (status.gap_a || status.fast_a) begin
                        drop_in  = 1'b1;
                        cause_in = CAUSE_NORMAL_REJ;
                        mode_in  = MODE_RECOVERY;
                     end else begin
                        cmd.anchor_wr = 1'b1;
                     end
                  end else if (status.gap_c || status.fast_c || status.fast_a) begin
                     drop_in  = 1'b1;
                     cause_in = CAUSE_RECOV_REJ;
                     mode_in  = MODE_RECOVERY;
                  end else if (mode_ff == MODE_FIRST_GOOD) begin
                     cmd.anchor_wr = 1'b1;
                     mode_in       = MODE_NORMAL;
                  end else begin
                     // first good fix: still dropped, but becomes the anchor
                     drop_in       = 1'b1;
                     cause_in      = CAUSE_FIRST_GOOD;
                     cmd.anchor_wr = 1'b1;
                     mode_in       = MODE_FIRST_GOOD;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_drop   = drop_ff;
   assign rsp_cause  = cause_ff;
   assign rsp_terr   = terr_ff;

endmodule

// ----- verif/tsgr_checker.sv -----
// Checker for the track spike and gap rejector: watches the fix, verdict and
// register channels, predicts each verdict and compares. Depends on tsgr_pkg.
module tsgr_checker
   import tsgr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [GAP_W-1:0]      csr_wdata,
   output int                    fixes_in,
   output int                    verdicts_out,
   output int                    fail_count,
   output logic [5:0]            causes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      TRK_NORMAL,
      TRK_RECOVERY,
      TRK_FIRST_GOOD
   } track_mode_type;

   typedef struct packed {
      logic signed [POS_W-1:0] z;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } fix_pos_type;

   typedef struct packed {
      logic               terr;
      logic [CAUSE_W-1:0] cause;
      logic               drop;
   } verdict_type;

   verdict_type         expected_verdicts[$];
   logic [SPEED_W-1:0]  lim_speed;
   logic [GAP_W-1:0]    lim_gap;
   track_mode_type      mode;
   bit                  anchored;
   logic [TIME_W-1:0]   anc_t;
   logic [TIME_W-1:0]   prv_t;
   fix_pos_type         anc_p;
   fix_pos_type         prv_p;

   // squared distance, wrapping at 64 bits
   function automatic logic [63:0] sq_dist(input fix_pos_type a, input fix_pos_type b);
      longint      d[3];
      logic [63:0] u;
      logic [63:0] s;
      d[0] = longint'(a.x) - longint'(b.x);
      d[1] = longint'(a.y) - longint'(b.y);
      d[2] = longint'(a.z) - longint'(b.z);
      s = '0;
      for (int i = 0; i < 3; i++) begin
         u = (d[i] < 0) ? -d[i] : d[i];
         s = s + u * u;
      end
      return s;
   endfunction

   // d2 * 10^6 > (dt * speed limit)^2, exact in 128 bits
   function automatic bit over_speed(input logic [63:0] d2, input logic [63:0] dt);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [63:0]  span;
      if (lim_speed == '0)
         return d2 != '0;
      if (dt >= 64'h0000_4000_0000_0000)
         return 1'b0;
      lhs = {64'd0, d2} * 128'd1000000;
      span = dt * {47'd0, lim_speed};
      rhs = {64'd0, span} * {64'd0, span};
      return lhs > rhs;
   endfunction

   function automatic verdict_type judge_fix(input bit start, input logic [TIME_W-1:0] t,
                                             input fix_pos_type p);
      verdict_type v;
      logic [63:0] dt_a;
      logic [63:0] dt_c;
      logic [63:0] d2_a;
      logic [63:0] d2_c;
      v = '0;
      if (start || !anchored) begin
         anchored = 1'b1;
         anc_t = t;
         anc_p = p;
         mode = TRK_NORMAL;
         v.cause = CAUSE_FIRST;
      end else if (t <= prv_t) begin
         // time went backward or stood still: flag it, keep all state
         v.drop = 1'b1;
         v.terr = 1'b1;
         v.cause = (mode == TRK_NORMAL) ? CAUSE_NORMAL_REJ : CAUSE_RECOV_REJ;
         return v;
      end else begin
         dt_a = {16'd0, t} - {16'd0, anc_t};
         d2_a = sq_dist(p, anc_p);
         if (mode == TRK_NORMAL) begin
            if (dt_a >= {37'd0, lim_gap} || over_speed(d2_a, dt_a)) begin
               v.drop = 1'b1;
               v.cause = CAUSE_NORMAL_REJ;
               mode = TRK_RECOVERY;
            end else begin
               anc_t = t;
               anc_p = p;
            end
         end else begin
            dt_c = {16'd0, t} - {16'd0, prv_t};
            d2_c = sq_dist(p, prv_p);
            if (dt_c > {37'd0, lim_gap} || over_speed(d2_c, dt_c) ||
                over_speed(d2_a, dt_a)) begin
               v.drop = 1'b1;
               v.cause = CAUSE_RECOV_REJ;
               mode = TRK_RECOVERY;
            end else if (mode == TRK_FIRST_GOOD) begin
               anc_t = t;
               anc_p = p;
               mode = TRK_NORMAL;
            end else begin
               // first good fix after a reject: drop it but re-anchor on it
               v.drop = 1'b1;
               v.cause = CAUSE_FIRST_GOOD;
               anc_t = t;
               anc_p = p;
               mode = TRK_FIRST_GOOD;
            end
         end
      end
      prv_t = t;
      prv_p = p;
      return v;
   endfunction

   always @(posedge clock) begin : monitor
      fix_pos_type p;
      verdict_type pred;
      verdict_type want;
      verdict_type got;
      int          errs;
      if (reset) begin
         expected_verdicts.delete();
         lim_speed = SPEED_LIM_RST;
         lim_gap = GAP_LIMIT_RST;
         mode = TRK_NORMAL;
         anchored = 1'b0;
         anc_t = '0;
         prv_t = '0;
         anc_p = '0;
         prv_p = '0;
         fixes_in <= 0;
         verdicts_out <= 0;
         fail_count <= 0;
         causes_seen <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPEED_LIM)
               lim_speed = csr_wdata[SPEED_W-1:0];
            else
               lim_gap = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            p.x = req_tdata[78:48];
            p.y = req_tdata[109:79];
            p.z = req_tdata[140:110];
            pred = judge_fix(req_tuser, req_tdata[TIME_W-1:0], p);
            expected_verdicts.insert(expected_verdicts.size(), pred);
            fixes_in <= fixes_in + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            verdicts_out <= verdicts_out + 1;
            got = rsp_tdata[4:0];
            if (expected_verdicts.size() == 0) begin
               $display("%0t: verdict %h arrived with no fix outstanding", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_verdicts.pop_front();
               errs = 0;
               if (got.drop !== want.drop) begin
                  $display("%0t: verdict %0d drop expected %0d actual %0d",
                           $time, verdicts_out, want.drop, got.drop);
                  errs++;
               end
               if (got.cause !== want.cause) begin
                  $display("%0t: verdict %0d cause expected %0d actual %0d",
                           $time, verdicts_out, want.cause, got.cause);
                  errs++;
               end
               if (got.terr !== want.terr) begin
                  $display("%0t: verdict %0d time_error expected %0d actual %0d",
                           $time, verdicts_out, want.terr, got.terr);
                  errs++;
               end
               fail_count <= fail_count + errs;
               causes_seen <= causes_seen | (6'd1 << want.cause) | {want.terr, 5'd0};
            end
         end
      end
   end

endmodule

// ----- verif/tb_track_spike_gap_rejector.sv -----
// Testbench top for the track spike and gap rejector: clock, reset, fix and
// register stimulus, output backpressure and verdict. Depends on tsgr_pkg,
// track_spike_gap_rejector and tsgr_checker.
module tb_track_spike_gap_rejector;
   timeunit 1ns;
   timeprecision 1ps;
   import tsgr_pkg::*;

   localparam int     QUIET_LIMIT = 4000;
   localparam longint POS_LIM     = 640000000;
   localparam longint BX          = 100000000;
   localparam longint BY          = -200000000;
   localparam longint BZ          = 300000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_index;
   logic [GAP_W-1:0]      csr_wdata;

   int                    fixes_in;
   int                    verdicts_out;
   int                    fail_count;
   logic [5:0]            causes_seen;
   int                    quiet = 0;
   int                    settings_used;

   // track generator state
   logic [TIME_W-1:0]     cur_t;
   longint                cur_x;
   longint                cur_y;
   longint                cur_z;
   logic [SPEED_W-1:0]    spd;
   logic [GAP_W-1:0]      gap;
   bit                    tx_burst;

   track_spike_gap_rejector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tsgr_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fixes_in     (fixes_in),
      .verdicts_out (verdicts_out),
      .fail_count   (fail_count),
      .causes_seen  (causes_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int tx_gap();
      int k;
      k = $urandom_range(99);
      if (tx_burst || k < 55)
         return 0;
      if (k < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > POS_LIM)
         return POS_LIM;
      if (v < -POS_LIM)
         return -POS_LIM;
      return v;
   endfunction

   function automatic longint rand_coord();
      case ($urandom_range(7))
         0:       return POS_LIM;
         1:       return -POS_LIM;
         default: return longint'($urandom_range(1280000000)) - POS_LIM;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      case ($urandom_range(3))
         0:       return 48'({$urandom, $urandom});
         1:       return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(100000));
         2:       return 48'($urandom_range(100000));
         default: return {16'($urandom), $urandom};
      endcase
   endfunction

   function automatic longint pick_dt();
      if (gap > 2)
         return $urandom_range((gap - 1 < 3000) ? gap - 1 : 3000, 1);
      return 1;
   endfunction

   task automatic send_fix(input bit start, input logic [TIME_W-1:0] t,
                           input longint x, input longint y, input longint z);
      int idle;
      idle = tx_gap();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= start;
      req_tdata <= {3'b000, 31'(z), 31'(y), 31'(x), t};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic idx, input logic [GAP_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // hold the input and wait for every outstanding verdict
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fixes_in != verdicts_out) @(posedge clock);
   endtask

   task automatic random_fix();
      int          k;
      bit          start;
      longint      dt;
      longint      lim;
      longint      h;
      logic [TIME_W-1:0] t;
      longint      x;
      longint      y;
      longint      z;
      k = $urandom_range(99);
      start = 1'b0;
      dt = pick_dt();
      t = cur_t + 48'(dt);
      x = cur_x;
      y = cur_y;
      z = cur_z;
      if (k < 4) begin
         start = 1'b1;
         t = rand_time();
         x = rand_coord();
         y = rand_coord();
         z = rand_coord();
         cur_t = t;
         cur_x = x;
         cur_y = y;
         cur_z = z;
      end else if (k < 7) begin
         t = rand_time();
         x = rand_coord();
         y = rand_coord();
         z = rand_coord();
      end else if (k < 12) begin
         t = cur_t - 48'($urandom_range(3));
      end else if (k < 22) begin
         // spike: jump away, true track stays put
         lim = $urandom_range(5000000, 1000000);
         x = clamp_pos(cur_x + ($urandom_range(1) ? lim : -lim));
         y = clamp_pos(cur_y + longint'($urandom_range(2000000)) - 1000000);
         cur_t = t;
      end else if (k < 27) begin
         // around the gap limit
         dt = longint'(gap) + longint'($urandom_range(2)) - 1;
         if (dt < 1)
            dt = 1;
         t = cur_t + 48'(dt);
         x = clamp_pos(cur_x + longint'($urandom_range(200)) - 100);
         cur_t = t;
         cur_x = x;
      end else if (k < 32) begin
         // at the speed limit (rounded down) or one centimetre over
         if (gap > 3000)
            dt = 1000 * $urandom_range(3, 1);
         t = cur_t + 48'(dt);
         lim = longint'(spd) * dt / 1000 + longint'($urandom_range(1));
         x = clamp_pos(cur_x + ($urandom_range(1) ? lim : -lim));
         cur_t = t;
         cur_x = x;
      end else begin
         lim = longint'(spd) * dt / 1000;
         h = lim / 2;
         x = clamp_pos(cur_x + longint'($urandom_range(2 * h)) - h);
         y = clamp_pos(cur_y + longint'($urandom_range(2 * h)) - h);
         z = clamp_pos(cur_z + longint'($urandom_range(2 * h)) - h);
         cur_t = t;
         cur_x = x;
         cur_y = y;
         cur_z = z;
      end
      send_fix(start, t, x, y, z);
   endtask

   // output side: random backpressure plus two long holds to fill the block
   initial begin : receiver
      int run_left;
      int hold_left;
      int style;
      int holds_done;
      run_left = 0;
      hold_left = 0;
      style = 0;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done < 2 && verdicts_out >= 120 + 180 * holds_done) begin
            hold_left = 400;
            holds_done++;
         end
         if (hold_left == 0) begin
            if (run_left == 0) begin
               run_left = $urandom_range(200, 20);
               style = $urandom_range(2);
            end
            run_left--;
            if (style == 1 && $urandom_range(99) < 3)
               hold_left = $urandom_range(60, 15);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (style == 0) || ($urandom_range(99) < ((style == 1) ? 70 : 35));
         end
      end
   end

   initial begin : stimulus
      int n_items;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SPEED_LIM;
      csr_wdata = '0;
      spd = SPEED_LIM_RST;
      gap = GAP_LIMIT_RST;
      tx_burst = 1'b0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset-default limits
      send_fix(1'b0, 48'd1000, BX, BY, BZ);
      send_fix(1'b0, 48'd2000, BX + 1000, BY, BZ);
      send_fix(1'b0, 48'd2000, BX + 1000, BY, BZ);
      send_fix(1'b0, 48'd1500, BX + 1000, BY, BZ);
      send_fix(1'b0, 48'd3000, BX + 4000, BY, BZ);
      send_fix(1'b0, 48'd4000, BX + 54000, BY, BZ);
      send_fix(1'b0, 48'd4000, BX + 4500, BY, BZ);
      send_fix(1'b0, 48'd5000, BX + 4500, BY, BZ);
      send_fix(1'b0, 48'd6000, BX + 4800, BY, BZ);
      send_fix(1'b0, 48'd7000, BX + 5800, BY, BZ);
      send_fix(1'b0, 48'd17000, BX + 5800, BY, BZ);
      send_fix(1'b0, 48'd27001, BX + 5800, BY, BZ);
      send_fix(1'b0, 48'd37001, BX + 5800, BY, BZ);
      send_fix(1'b0, 48'd37002, BX + 5800, BY, BZ);
      send_fix(1'b1, 48'hFFFF_FFFF_FFFF, POS_LIM, -POS_LIM, POS_LIM);
      send_fix(1'b0, 48'd0, -POS_LIM, POS_LIM, -POS_LIM);
      send_fix(1'b1, 48'd0, -POS_LIM, POS_LIM, -POS_LIM);
      send_fix(1'b0, 48'd1, -POS_LIM, POS_LIM, -POS_LIM);
      send_fix(1'b0, 48'd2, POS_LIM, -POS_LIM, POS_LIM);
      send_fix(1'b1, 48'h8000_0000_0000, 0, 0, 0);
      cur_t = 48'h8000_0000_0000;
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: begin spd = 17'd100000; gap = 27'd86400000; end
            1: begin spd = '0; gap = '0; end
            2: begin spd = '0; gap = 27'd5000; end
            3: begin spd = SPEED_LIM_RST; gap = GAP_LIMIT_RST; end
            default: begin
               spd = 17'($urandom_range(100000));
               gap = ($urandom_range(3) == 0) ? 27'($urandom_range(86400000))
                                               : 27'($urandom_range(20000, 500));
            end
         endcase
         write_reg(CSR_SPEED_LIM, GAP_W'(spd));
         write_reg(CSR_GAP_LIMIT, gap);
         settings_used++;
         tx_burst = ($urandom_range(3) == 0);
         n_items = (ph == 1) ? 30 : 60;
         repeat (n_items) random_fix();
      end

      drain();
      repeat (40) @(posedge clock);
      $display("checked %0d verdicts for %0d fixes under %0d limit settings, both sides stalled",
               verdicts_out, fixes_in, settings_used);
      $display("verdict kinds seen (time error, first good, recovery, normal, first, kept): %b",
               causes_seen);
      if (fail_count == 0 && fixes_in == verdicts_out) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
